// ----- rtl/cdse_pkg.sv -----
package cdse_pkg;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 16;

	// internal year carries one extra bit so that MAX_YEAR + 1 is visible
	localparam int unsigned YACC_W = YEAR_W + 1;

	localparam logic [YACC_W-1:0] MAX_YEAR      = YACC_W'(9999);
	localparam logic [YACC_W-1:0] MIN_YEAR      = YACC_W'(1900);
	localparam logic [19:0]       MAX_DAY_COUNT = 20'd65535;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SUB   = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// micro-op and branch condition of one control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHECK,
		OP_STEP,
		OP_RANGE,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_SKIP,
		COND_MORE,
		COND_OUT_FREE
	} ucond_t;

	typedef logic [2:0] uaddr_t;

	localparam uaddr_t UA_IDLE  = 3'd0;
	localparam uaddr_t UA_CHECK = 3'd1;
	localparam uaddr_t UA_STEP  = 3'd2;
	localparam uaddr_t UA_RANGE = 3'd3;
	localparam uaddr_t UA_DONE  = 3'd4;

	typedef struct packed {
		uop_t   op;
		ucond_t cond;
		uaddr_t tgt_t;
		uaddr_t tgt_f;
	} uword_t;

	// control toward the datapath
	typedef struct packed {
		uop_t op;
		logic fire;
	} dp_ctl_t;

	// status back to the sequencer
	typedef struct packed {
		logic skip;
		logic more;
		logic out_free;
	} dp_stat_t;

	// control store
	function automatic uword_t ucode_rom(input uaddr_t a);
		uword_t w;
		unique case (a)
			UA_IDLE:  w = '{OP_LOAD,  COND_IN_VALID, UA_CHECK, UA_IDLE};
			UA_CHECK: w = '{OP_CHECK, COND_SKIP,     UA_DONE,  UA_STEP};
			UA_STEP:  w = '{OP_STEP,  COND_MORE,     UA_STEP,  UA_RANGE};
			UA_RANGE: w = '{OP_RANGE, COND_ALWAYS,   UA_DONE,  UA_DONE};
			UA_DONE:  w = '{OP_EMIT,  COND_OUT_FREE, UA_IDLE,  UA_DONE};
			default:  w = '{OP_NOP,   COND_ALWAYS,   UA_IDLE,  UA_IDLE};
		endcase
		return w;
	endfunction

	// month length, leap rule is year divisible by 4
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
			input logic [1:0] ylo);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = (ylo == 2'd0) ? 5'd29 : 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic year_ok(input logic [YACC_W-1:0] y);
		return (y >= MIN_YEAR) && (y <= MAX_YEAR);
	endfunction

endpackage

// ----- rtl/cdse_in_if.sv -----
interface cdse_in_if import cdse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [MONTH_W-1:0] month_in;
	logic [DAY_W-1:0]   day_in;
	logic [YEAR_W-1:0]  year_in;
	logic [COUNT_W-1:0] day_count;

	modport source (output valid, command, month_in, day_in, year_in, day_count,
		input ready);
	modport sink (input valid, command, month_in, day_in, year_in, day_count,
		output ready);
endinterface

// ----- rtl/cdse_out_if.sv -----
interface cdse_out_if import cdse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MONTH_W-1:0] month_out;
	logic [DAY_W-1:0]   day_out;
	logic [YEAR_W-1:0]  year_out;
	logic               date_valid;

	modport source (output valid, month_out, day_out, year_out, date_valid,
		input ready);
	modport sink (input valid, month_out, day_out, year_out, date_valid,
		output ready);
endinterface

// ----- rtl/cdse_useq.sv -----
module cdse_useq import cdse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	uaddr_t upc_q;
	uword_t uw;
	logic   cond_true;

	assign uw = ucode_rom(upc_q);

	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:   cond_true = 1'b1;
			COND_IN_VALID: cond_true = in_valid;
			COND_SKIP:     cond_true = stat.skip;
			COND_MORE:     cond_true = stat.more;
			COND_OUT_FREE: cond_true = stat.out_free;
			default:       cond_true = 1'b1;
		endcase
	end

	assign ctl.op   = uw.op;
	assign ctl.fire = cond_true;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= cond_true ? uw.tgt_t : uw.tgt_f;
		end
	end

endmodule

// ----- rtl/cdse_dpath.sv -----
module cdse_dpath import cdse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_ctl_t            ctl,
	output dp_stat_t           stat,
	input  logic [CMD_W-1:0]   command,
	input  logic [MONTH_W-1:0] month_in,
	input  logic [DAY_W-1:0]   day_in,
	input  logic [YEAR_W-1:0]  year_in,
	input  logic [COUNT_W-1:0] day_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [MONTH_W-1:0] month_out,
	output logic [DAY_W-1:0]   day_out,
	output logic [YEAR_W-1:0]  year_out,
	output logic               date_valid
);

	logic [CMD_W-1:0]   cmd_q;
	logic [MONTH_W-1:0] m_q;
	logic [DAY_W-1:0]   d_q;
	logic [YACC_W-1:0]  y_q;
	logic [COUNT_W-1:0] n_q;
	logic               valid_q;
	logic               out_valid_q;

	logic [COUNT_W-1:0] n_load;
	logic [DAY_W-1:0]   dim;
	logic               date_good;
	logic               stepping;
	logic [MONTH_W-1:0] m_nxt;
	logic [DAY_W-1:0]   d_nxt;
	logic [YACC_W-1:0]  y_nxt;
	logic [MONTH_W-1:0] m_back;
	logic [YACC_W-1:0]  y_back;

	// clamp of the requested count
	assign n_load = ({4'd0, day_count} > MAX_DAY_COUNT) ? MAX_DAY_COUNT[COUNT_W-1:0]
		: day_count;

	assign dim       = days_in(m_q, y_q[1:0]);
	assign date_good = year_ok(y_q) && (m_q >= MONTH_JAN) && (m_q <= MONTH_DEC)
		&& (d_q >= 5'd1) && (d_q <= dim);
	assign stepping  = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);

	// previous month, used when stepping back across a month boundary
	assign m_back = (m_q == MONTH_JAN) ? MONTH_DEC : MONTH_W'(m_q - 4'd1);
	assign y_back = (m_q == MONTH_JAN) ? YACC_W'(y_q - 15'd1) : y_q;

	// one day forward or back
	always_comb begin
		m_nxt = m_q;
		d_nxt = d_q;
		y_nxt = y_q;
		if (cmd_q == CMD_ADD) begin
			if (d_q >= dim) begin
				d_nxt = 5'd1;
				if (m_q == MONTH_DEC) begin
					m_nxt = MONTH_JAN;
					y_nxt = YACC_W'(y_q + 15'd1);
				end else begin
					m_nxt = MONTH_W'(m_q + 4'd1);
				end
			end else begin
				d_nxt = DAY_W'(d_q + 5'd1);
			end
		end else begin
			if (d_q <= 5'd1) begin
				m_nxt = m_back;
				y_nxt = y_back;
				d_nxt = days_in(m_back, y_back[1:0]);
			end else begin
				d_nxt = DAY_W'(d_q - 5'd1);
			end
		end
	end

	assign stat.skip     = !date_good || !stepping || (n_q == '0);
	assign stat.more     = (n_q != COUNT_W'(1)) && year_ok(y_nxt);
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (ctl.fire) begin
					cmd_q <= command;
					m_q   <= month_in;
					d_q   <= day_in;
					y_q   <= {1'b0, year_in};
					n_q   <= n_load;
				end
			end
			OP_CHECK: valid_q <= date_good;
			OP_STEP: begin
				m_q <= m_nxt;
				d_q <= d_nxt;
				y_q <= y_nxt;
				n_q <= COUNT_W'(n_q - 16'd1);
			end
			OP_RANGE: valid_q <= valid_q && year_ok(y_q);
			OP_EMIT: begin
				if (ctl.fire) begin
					month_out  <= m_q;
					day_out    <= d_q;
					year_out   <= y_q[YEAR_W-1:0];
					date_valid <= valid_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && ctl.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/calendar_date_step_engine_core.sv -----
// calendar date step engine
// requests arrive on cmd_ch: a command (validate, add days, subtract days), a
// month/day/year start date and a day count. results leave on res_ch: the
// resulting date and a valid flag, one result per request.
// control is a five-word microprogram in a read-only control store; a micro
// program counter walks it and drives a small date datapath.
// micro-words from request accept to result valid:
//   validate only, invalid date, other command or zero count: check, emit
//   add or subtract: check, steps, range check, emit
// the count is clamped to MAX_DAY_COUNT. the step micro-word advances the
// date by exactly one day per cycle and loops on itself, so that loop sets
// the throughput: a request is taken only once the last one has been emitted.
// stepping stops early at the first date outside 1900..MAX_YEAR.
// the result sits in an output register; the next request is accepted while
// it waits. if the receiver stalls, a further finished result holds in the
// datapath until the output register frees up, and no request is taken then.
// reset (arst_n low) returns the sequencer to its idle word and empties the
// output register; no result is lost or duplicated otherwise.
module calendar_date_step_engine_core import cdse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	cdse_in_if.sink      cmd_ch,
	cdse_out_if.source   res_ch
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// microprogram sequencer
	cdse_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	// request is taken only on the idle micro-word
	assign cmd_ch.ready = (ctl.op == OP_LOAD);

	// date datapath with the output register
	cdse_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.command    (cmd_ch.command),
		.month_in   (cmd_ch.month_in),
		.day_in     (cmd_ch.day_in),
		.year_in    (cmd_ch.year_in),
		.day_count  (cmd_ch.day_count),
		.out_valid  (res_ch.valid),
		.out_ready  (res_ch.ready),
		.month_out  (res_ch.month_out),
		.day_out    (res_ch.day_out),
		.year_out   (res_ch.year_out),
		.date_valid (res_ch.date_valid)
	);

endmodule

// ----- rtl/cdse_chk.sv -----
module cdse_chk import cdse_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [MONTH_W-1:0] month_out,
	input logic [DAY_W-1:0]   day_out,
	input logic [YEAR_W-1:0]  year_out,
	input logic               date_valid
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(month_out) && $stable(day_out)
			&& $stable(year_out) && $stable(date_valid))
		else $error("result changed while stalled");

	// a request always passes the check word before the next one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken back to back");

	// a result flagged valid is a real date within range
	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && date_valid |-> (month_out >= MONTH_JAN) && (month_out <= MONTH_DEC)
			&& (day_out >= 5'd1) && (day_out <= days_in(month_out, year_out[1:0]))
			&& ({1'b0, year_out} >= MIN_YEAR) && ({1'b0, year_out} <= MAX_YEAR))
		else $error("valid flag on out-of-range date");

endmodule

bind calendar_date_step_engine_core cdse_chk u_cdse_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd_ch.valid),
	.cmd_ready  (cmd_ch.ready),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.month_out  (res_ch.month_out),
	.day_out    (res_ch.day_out),
	.year_out   (res_ch.year_out),
	.date_valid (res_ch.date_valid)
);
